>>> rtl/core/smartcard_atr_sniffer_top_macros.svh
// Assertion macros shared by the smartcard ATR sniffer RTL.
`ifndef SMARTCARD_ATR_SNIFFER_TOP_MACROS_SVH
`define SMARTCARD_ATR_SNIFFER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every clk edge, skipped while rst is high.
`define SCATR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clk edge, reset included.
`define SCATR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCATR_ASSERT(lbl, prop, msg)
`define SCATR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/scatr_pkg.sv
// Types, constants and table functions of the smartcard ATR sniffer.
`default_nettype none
package scatr_pkg;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int PHASE_W  = 3;
  localparam int STEP_W   = 4;
  localparam int RATIO_W  = 10;
  localparam int WAIT_W   = 24;
  localparam int WI_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INIT_WAIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEF_WI    = 1'b1;

  // Reset values
  localparam logic [WAIT_W-1:0]  INIT_WAIT_RST = 24'd9600;
  localparam logic [WI_W-1:0]    DEF_WI_RST    = 8'd10;
  localparam logic [RATIO_W-1:0] RATIO_RST     = 10'd372;
  localparam logic [3:0]         RATE_IDX_RST  = 4'd1;
  localparam logic [17:0]        RATIO_LIMIT   = 18'h400;

  // Presence bits of a format byte (T0 or TDi)
  localparam int Y_TA = 4;
  localparam int Y_TB = 5;
  localparam int Y_TC = 6;
  localparam int Y_TD = 7;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE      = 2'd0,
    OP_RESET_ON  = 2'd1,
    OP_RESET_OFF = 2'd2,
    OP_EXPIRE    = 2'd3
  } op_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_RESET     = 3'd0,
    PH_WAIT_ATR  = 3'd1,
    PH_IN_ATR    = 3'd2,
    PH_WAIT_APDU = 3'd3,
    PH_IN_APDU   = 3'd4
  } phase_t;

  typedef enum logic [STEP_W-1:0] {
    AS_TS   = 4'd0,
    AS_T0   = 4'd1,
    AS_TA   = 4'd2,
    AS_TB   = 4'd3,
    AS_TC   = 4'd4,
    AS_TD   = 4'd5,
    AS_HIST = 4'd6,
    AS_TCK  = 4'd7,
    AS_DONE = 4'd8
  } atr_step_t;

  typedef struct packed {
    logic [WAIT_W-1:0] initial_wait_time;
    logic [WI_W-1:0]   default_wait_index;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    atr_step_t          atr_step;
    logic               trace_valid;
    logic [BYTE_W-1:0]  trace_byte;
    logic               atr_started;
    logic               apdu_end;
    logic               ratio_load;
    logic [RATIO_W-1:0] ratio_value;
    logic               ratio_unsupported;
    logic               wait_load;
    logic [WAIT_W-1:0]  wait_time;
  } result_t;

  // Di as a power-of-two shift; valid low where D is RFU
  typedef struct packed {
    logic       valid;
    logic [2:0] shift;
  } d_adj_t;

  typedef struct packed {
    logic               ok;
    logic [RATIO_W-1:0] value;
  } ratio_t;

  // Fi table (clock rate conversion factor), 0 for RFU codes
  function automatic logic [11:0] clk_rate(input logic [3:0] fi);
    logic [11:0] f;
    case (fi)
      4'd1:    f = 12'd372;
      4'd2:    f = 12'd558;
      4'd3:    f = 12'd744;
      4'd4:    f = 12'd1116;
      4'd5:    f = 12'd1488;
      4'd6:    f = 12'd1860;
      4'd9:    f = 12'd512;
      4'd10:   f = 12'd768;
      4'd11:   f = 12'd1024;
      4'd12:   f = 12'd1536;
      4'd13:   f = 12'd2048;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

  // Di table: codes below 8 divide F, codes from 8 up multiply it
  function automatic d_adj_t baud_adj(input logic [3:0] di);
    d_adj_t d;
    d.valid = 1'b1;
    case (di)
      4'd1:    d.shift = 3'd0;
      4'd2:    d.shift = 3'd1;
      4'd3:    d.shift = 3'd2;
      4'd4:    d.shift = 3'd3;
      4'd5:    d.shift = 3'd4;
      4'd10:   d.shift = 3'd1;
      4'd11:   d.shift = 3'd2;
      4'd12:   d.shift = 3'd3;
      4'd13:   d.shift = 3'd4;
      4'd14:   d.shift = 3'd5;
      4'd15:   d.shift = 3'd6;
      default: begin
        d.valid = 1'b0;
        d.shift = 3'd0;
      end
    endcase
    return d;
  endfunction

  // Clock cycles per ETU from Fi/Di, with a flag for usable ratios
  function automatic ratio_t calc_ratio(input logic [3:0] fi, input logic [3:0] di);
    logic [11:0] f;
    d_adj_t      d;
    logic [17:0] r;
    ratio_t      res;
    f = clk_rate(fi);
    d = baud_adj(di);
    if (di[3]) begin
      r = {6'd0, f} << d.shift;
    end else begin
      r = {6'd0, f} >> d.shift;
    end
    res.ok    = (f != 12'd0) && d.valid && (r != 18'd0) && (r < RATIO_LIMIT);
    res.value = r[RATIO_W-1:0];
    return res;
  endfunction

  // Waiting time 960 * D * WI, truncated to 24 bits; 960 = 1024 - 64
  function automatic logic [WAIT_W-1:0] wait_calc(input logic [3:0] di,
                                                  input logic [WI_W-1:0] wi);
    d_adj_t            d;
    logic [17:0]       prod;
    logic [WAIT_W-1:0] full;
    d    = baud_adj(di);
    prod = {wi, 10'd0} - {4'd0, wi, 6'd0};
    full = {6'd0, prod} << d.shift;
    return d.valid ? full : '0;
  endfunction

  // Next interface byte after 'from', per the presence bits of y
  function automatic atr_step_t next_interface(input atr_step_t from,
                                               input logic [7:0] y,
                                               input logic [3:0] hist);
    atr_step_t nxt;
    if (from < AS_TA && y[Y_TA]) begin
      nxt = AS_TA;
    end else if (from < AS_TB && y[Y_TB]) begin
      nxt = AS_TB;
    end else if (from < AS_TC && y[Y_TC]) begin
      nxt = AS_TC;
    end else if (y[Y_TD]) begin
      nxt = AS_TD;
    end else begin
      nxt = AS_HIST;
    end
    // no historical bytes: straight to TCK
    if (nxt == AS_HIST && hist == 4'd0) begin
      nxt = AS_TCK;
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/scatr_cfg.sv
// Configuration registers of the smartcard ATR sniffer.
`default_nettype none
module scatr_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [scatr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scatr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output scatr_pkg::cfg_t                          cfg
);
  import scatr_pkg::*;

  logic [WAIT_W-1:0] initial_wait_time;
  logic [WI_W-1:0]   default_wait_index;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_wait_time  <= INIT_WAIT_RST;
      default_wait_index <= DEF_WI_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_INIT_WAIT: initial_wait_time  <= cfg_data[WAIT_W-1:0];
        CFG_IDX_DEF_WI:    default_wait_index <= cfg_data[WI_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.initial_wait_time  = initial_wait_time;
  assign cfg.default_wait_index = default_wait_index;

endmodule
`default_nettype wire

>>> rtl/core/scatr_engine.sv
// Session phase tracker and ATR parser: state and one-beat step logic.
`default_nettype none
module scatr_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step_en,
  input  wire scatr_pkg::op_t                   op,
  input  wire logic [scatr_pkg::BYTE_W-1:0]     data_byte,
  input  wire scatr_pkg::cfg_t                  cfg,
  output scatr_pkg::result_t                    res
);
  import scatr_pkg::*;

  phase_t             session_phase, session_phase_next;
  atr_step_t          atr_substate, atr_substate_next;
  logic [7:0]         last_format_byte, last_format_byte_next;
  logic [3:0]         group_number, group_number_next;
  logic [3:0]         hist_left, hist_left_next;
  logic [3:0]         rate_index_f, rate_index_f_next;
  logic [3:0]         rate_index_d, rate_index_d_next;
  logic [WI_W-1:0]    wait_index, wait_index_next;
  logic [RATIO_W-1:0] current_ratio, current_ratio_next;
  logic [WAIT_W-1:0]  current_wait, current_wait_next;

  ratio_t             ratio_tck;
  ratio_t             ratio_dflt;
  logic [WAIT_W-1:0]  wait_tck;
  logic [3:0]         hist_dec;

  assign ratio_tck  = calc_ratio(rate_index_f, rate_index_d);
  assign ratio_dflt = calc_ratio(RATE_IDX_RST, RATE_IDX_RST);
  assign wait_tck   = wait_calc(rate_index_d, wait_index);
  assign hist_dec   = (hist_left != 4'd0) ? hist_left - 4'd1 : hist_left;

  // step logic
  always_comb begin
    session_phase_next    = session_phase;
    atr_substate_next     = atr_substate;
    last_format_byte_next = last_format_byte;
    group_number_next     = group_number;
    hist_left_next        = hist_left;
    rate_index_f_next     = rate_index_f;
    rate_index_d_next     = rate_index_d;
    wait_index_next       = wait_index;
    current_ratio_next    = current_ratio;
    current_wait_next     = current_wait;
    res                   = '0;

    case (op)
      OP_RESET_ON: begin
        session_phase_next = PH_RESET;
      end
      OP_RESET_OFF: begin
        rate_index_f_next = RATE_IDX_RST;
        rate_index_d_next = RATE_IDX_RST;
        if (ratio_dflt.ok) begin
          current_ratio_next = ratio_dflt.value;
          res.ratio_load     = 1'b1;
        end else begin
          res.ratio_unsupported = 1'b1;
        end
        wait_index_next       = cfg.default_wait_index;
        current_wait_next     = cfg.initial_wait_time;
        res.wait_load         = 1'b1;
        atr_substate_next     = AS_TS;
        last_format_byte_next = 8'd0;
        group_number_next     = 4'd0;
        hist_left_next        = 4'd0;
        res.atr_started       = 1'b1;
        session_phase_next    = PH_WAIT_ATR;
      end
      OP_EXPIRE: begin
        res.apdu_end       = 1'b1;
        session_phase_next = PH_WAIT_APDU;
      end
      OP_BYTE: begin
        res.trace_valid = 1'b1;
        res.trace_byte  = data_byte;
        if (session_phase == PH_WAIT_ATR || session_phase == PH_IN_ATR) begin
          session_phase_next = PH_IN_ATR;
          case (atr_substate)
            AS_TS: begin
              // a zero TS is not taken as the initial character
              if (data_byte != 8'd0) begin
                atr_substate_next = AS_T0;
              end
            end
            AS_T0: begin
              hist_left_next        = data_byte[3:0];
              last_format_byte_next = {data_byte[7:4], 4'd0};
              group_number_next     = 4'd1;
              atr_substate_next     = next_interface(AS_TS, {data_byte[7:4], 4'd0},
                                                     data_byte[3:0]);
            end
            AS_TA: begin
              if (group_number == 4'd1) begin
                rate_index_f_next = data_byte[7:4];
                rate_index_d_next = data_byte[3:0];
              end
              atr_substate_next = next_interface(AS_TA, last_format_byte, hist_left);
            end
            AS_TB: begin
              atr_substate_next = next_interface(AS_TB, last_format_byte, hist_left);
            end
            AS_TC: begin
              if (group_number == 4'd2) begin
                wait_index_next = data_byte;
              end
              atr_substate_next = next_interface(AS_TC, last_format_byte, hist_left);
            end
            AS_TD: begin
              last_format_byte_next = data_byte;
              if (group_number != 4'd15) begin
                group_number_next = group_number + 4'd1;
              end
              atr_substate_next = next_interface(AS_TS, data_byte, hist_left);
            end
            AS_HIST: begin
              hist_left_next = hist_dec;
              if (hist_dec == 4'd0) begin
                atr_substate_next = AS_TCK;
              end
            end
            AS_TCK: begin
              atr_substate_next = AS_DONE;
              if (ratio_tck.ok) begin
                current_ratio_next = ratio_tck.value;
                res.ratio_load     = 1'b1;
              end else begin
                res.ratio_unsupported = 1'b1;
              end
              current_wait_next  = wait_tck;
              res.wait_load      = 1'b1;
              session_phase_next = PH_WAIT_APDU;
            end
            default: ;
          endcase
        end else if (session_phase == PH_WAIT_APDU || session_phase == PH_IN_APDU) begin
          session_phase_next = PH_IN_APDU;
        end
      end
      default: ;
    endcase

    res.phase       = session_phase_next;
    res.atr_step    = atr_substate_next;
    res.ratio_value = current_ratio_next;
    res.wait_time   = current_wait_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      session_phase    <= PH_RESET;
      atr_substate     <= AS_TS;
      last_format_byte <= 8'd0;
      group_number     <= 4'd0;
      hist_left        <= 4'd0;
      rate_index_f     <= RATE_IDX_RST;
      rate_index_d     <= RATE_IDX_RST;
      wait_index       <= DEF_WI_RST;
      current_ratio    <= RATIO_RST;
      current_wait     <= INIT_WAIT_RST;
    end else if (step_en) begin
      session_phase    <= session_phase_next;
      atr_substate     <= atr_substate_next;
      last_format_byte <= last_format_byte_next;
      group_number     <= group_number_next;
      hist_left        <= hist_left_next;
      rate_index_f     <= rate_index_f_next;
      rate_index_d     <= rate_index_d_next;
      wait_index       <= wait_index_next;
      current_ratio    <= current_ratio_next;
      current_wait     <= current_wait_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/smartcard_atr_sniffer_top.sv
// Top level of the smartcard ATR sniffer: input register, engine, result register.
//
//   channel  | direction | beat contents
//   ---------+-----------+---------------------------------------------------
//   s_*      | in        | tuser: op; tdata: data_byte
//   m_*      | out       | tdata: phase .. wait_time (see port comment)
//   cfg_*    | in        | cfg_index selects register, cfg_data holds value
//
// One beat per cycle in each direction while m_tready is high; a beat taken on s_*
// waits in the input register and shows on m_* once it enters the result register.
// The engine state advances when a beat moves from the input to the result register.
// rst is synchronous: session in reset, ATR parser at TS, registers at defaults.
// A stall on m_tready holds the result; s_tready drops only while both registers are
// full and m_tready is low.
`default_nettype none
`include "smartcard_atr_sniffer_top_macros.svh"
module smartcard_atr_sniffer_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [scatr_pkg::IN_DATA_W-1:0]      s_tdata,  // [7:0] data_byte
  input  wire logic [scatr_pkg::IN_USER_W-1:0]      s_tuser,  // [1:0] op
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [2:0] phase, [6:3] atr_step, [7] trace_valid, [15:8] trace_byte,
  // [16] atr_started, [17] apdu_end, [18] ratio_load, [28:19] ratio_value,
  // [29] ratio_unsupported, [30] wait_load, [54:31] wait_time, [55] zero
  output logic [scatr_pkg::OUT_DATA_W-1:0]          m_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [scatr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [scatr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scatr_pkg::*;

  cfg_t              cfg;
  result_t           step_res;
  result_t           out_res;
  logic              in_valid;
  op_t               in_op;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  logic              advance;

  scatr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scatr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .op        (in_op),
    .data_byte (in_byte),
    .cfg       (cfg),
    .res       (step_res)
  );

  // a beat moves on when the result register is empty or being drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= op_t'(s_tuser[OP_W-1:0]);
      in_byte <= s_tdata[BYTE_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  // output packing
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0,
                     out_res.wait_time,
                     out_res.wait_load,
                     out_res.ratio_unsupported,
                     out_res.ratio_value,
                     out_res.ratio_load,
                     out_res.apdu_end,
                     out_res.atr_started,
                     out_res.trace_byte,
                     out_res.trace_valid,
                     out_res.atr_step,
                     out_res.phase};

  // checks
  `SCATR_ASSERT(a_held_input, in_valid && !advance |=> in_valid && $stable(in_op) && $stable(in_byte), "input register lost a stalled beat")
  `SCATR_ASSERT(a_advance_fills, advance |=> out_valid, "result register not filled after a step")
  `SCATR_ASSERT(a_ratio_flags, out_valid |-> !(out_res.ratio_load && out_res.ratio_unsupported), "ratio both loaded and refused")
  `SCATR_ASSERT(a_atr_start, out_valid && out_res.atr_started |-> out_res.phase == PH_WAIT_ATR && out_res.atr_step == AS_TS && out_res.wait_load, "ATR start with wrong session state")
  `SCATR_ASSERT(a_apdu_end, out_valid && out_res.apdu_end |-> out_res.phase == PH_WAIT_APDU && !out_res.trace_valid, "expiry did not close the trace unit")

endmodule
`default_nettype wire

>>> tb/atr_session_checker.sv
// Checker for the smartcard ATR sniffer: tracks session and ATR parse state, checks every result beat.
module atr_session_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [scatr_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [scatr_pkg::IN_USER_W-1:0]     s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [scatr_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [scatr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scatr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                  mismatch_count,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import scatr_pkg::*;

  localparam int unsigned ETU_PER_WI = 960;

  typedef struct packed {
    phase_t             phase;
    atr_step_t          step;
    logic               trace_valid;
    logic [BYTE_W-1:0]  trace_byte;
    logic               atr_started;
    logic               apdu_end;
    logic               ratio_load;
    logic [RATIO_W-1:0] ratio_value;
    logic               ratio_unsupported;
    logic               wait_load;
    logic [WAIT_W-1:0]  wait_time;
  } sniff_beat_t;

  // configuration copy
  logic [WAIT_W-1:0]  cfg_init_wait;
  logic [WI_W-1:0]    cfg_def_wi;

  // session and parser state
  phase_t             sess_phase;
  atr_step_t          parse_step;
  logic [7:0]         format_byte;
  logic [3:0]         group_cnt;
  logic [3:0]         hist_cnt;
  logic [3:0]         fi_code;
  logic [3:0]         di_code;
  logic [WI_W-1:0]    wi;
  logic [RATIO_W-1:0] clk_per_etu;
  logic [WAIT_W-1:0]  wait_etu;

  sniff_beat_t predicted_beats[$];

  // Fi: clock cycles per ETU before the D adjustment, 0 where reserved
  function automatic int unsigned fi_clocks(input logic [3:0] code);
    case (code)
      4'h1: return 372;
      4'h2: return 558;
      4'h3: return 744;
      4'h4: return 1116;
      4'h5: return 1488;
      4'h6: return 1860;
      4'h9: return 512;
      4'hA: return 768;
      4'hB: return 1024;
      4'hC: return 1536;
      4'hD: return 2048;
      default: return 0;
    endcase
  endfunction

  // Di: baud adjustment factor, 0 where reserved
  function automatic int unsigned di_factor(input logic [3:0] code);
    if (code >= 4'h1 && code <= 4'h5) return 1 << (code - 1);
    if (code >= 4'hA) return 1 << (code - 9);
    return 0;
  endfunction

  // F/D ratio; returns 0 when the pair is reserved or out of range
  function automatic logic ratio_from(input logic [3:0] fi, input logic [3:0] di,
                                      output logic [RATIO_W-1:0] ratio);
    int unsigned f;
    int unsigned d;
    int unsigned r;
    f = fi_clocks(fi);
    d = di_factor(di);
    ratio = '0;
    if (f == 0 || d == 0) return 1'b0;
    r = (di < 4'd8) ? f / d : f * d;
    if (r == 0 || r >= RATIO_LIMIT) return 1'b0;
    ratio = r[RATIO_W-1:0];
    return 1'b1;
  endfunction

  // Next interface byte after 'after', lowest present one wins
  function automatic atr_step_t next_field(input atr_step_t after);
    atr_step_t n;
    n = AS_HIST;
    if (format_byte[Y_TD]) n = AS_TD;
    if (format_byte[Y_TC] && after < AS_TC) n = AS_TC;
    if (format_byte[Y_TB] && after < AS_TB) n = AS_TB;
    if (format_byte[Y_TA] && after < AS_TA) n = AS_TA;
    if (n == AS_HIST && hist_cnt == 4'd0) n = AS_TCK;
    return n;
  endfunction

  // Advance the session by one input beat and build the expected result
  task automatic advance_session(input op_t op, input logic [7:0] b, output sniff_beat_t nb);
    logic [RATIO_W-1:0] r;
    phase_t             next_ph;
    int unsigned        w;
    nb = '0;
    case (op)
      OP_RESET_ON: sess_phase = PH_RESET;
      OP_RESET_OFF: begin
        fi_code = RATE_IDX_RST;
        di_code = RATE_IDX_RST;
        if (ratio_from(fi_code, di_code, r)) begin
          clk_per_etu = r;
          nb.ratio_load = 1'b1;
        end else begin
          nb.ratio_unsupported = 1'b1;
        end
        wi          = cfg_def_wi;
        wait_etu    = cfg_init_wait;
        nb.wait_load = 1'b1;
        parse_step  = AS_TS;
        format_byte = '0;
        group_cnt   = '0;
        hist_cnt    = '0;
        nb.atr_started = 1'b1;
        sess_phase  = PH_WAIT_ATR;
      end
      OP_EXPIRE: begin
        nb.apdu_end = 1'b1;
        sess_phase  = PH_WAIT_APDU;
      end
      default: begin
        nb.trace_valid = 1'b1;
        nb.trace_byte  = b;
        if (sess_phase == PH_WAIT_ATR || sess_phase == PH_IN_ATR) begin
          next_ph = PH_IN_ATR;
          case (parse_step)
            AS_TS: begin
              // a null TS is skipped
              if (b != 8'h00) parse_step = AS_T0;
            end
            AS_T0: begin
              hist_cnt    = b[3:0];
              format_byte = {b[7:4], 4'h0};
              group_cnt   = 4'd1;
              parse_step  = next_field(AS_TS);
            end
            AS_TA: begin
              if (group_cnt == 4'd1) begin
                fi_code = b[7:4];
                di_code = b[3:0];
              end
              parse_step = next_field(AS_TA);
            end
            AS_TB: parse_step = next_field(AS_TB);
            AS_TC: begin
              if (group_cnt == 4'd2) wi = b;
              parse_step = next_field(AS_TC);
            end
            AS_TD: begin
              format_byte = b;
              if (group_cnt != 4'd15) group_cnt = group_cnt + 4'd1;
              parse_step = next_field(AS_TS);
            end
            AS_HIST: begin
              if (hist_cnt != 4'd0) hist_cnt = hist_cnt - 4'd1;
              if (hist_cnt == 4'd0) parse_step = AS_TCK;
            end
            AS_TCK: begin
              parse_step = AS_DONE;
              if (ratio_from(fi_code, di_code, r)) begin
                clk_per_etu = r;
                nb.ratio_load = 1'b1;
              end else begin
                nb.ratio_unsupported = 1'b1;
              end
              w = ETU_PER_WI * di_factor(di_code) * wi;
              wait_etu = w[WAIT_W-1:0];
              nb.wait_load = 1'b1;
              next_ph = PH_WAIT_APDU;
            end
            default: ;
          endcase
          sess_phase = next_ph;
        end else if (sess_phase == PH_WAIT_APDU || sess_phase == PH_IN_APDU) begin
          sess_phase = PH_IN_APDU;
        end
      end
    endcase
    nb.phase       = sess_phase;
    nb.step        = parse_step;
    nb.ratio_value = clk_per_etu;
    nb.wait_time   = wait_etu;
  endtask

  // Field layout of m_tdata, lowest bit first
  function automatic sniff_beat_t unpack_beat(input logic [OUT_DATA_W-1:0] d);
    sniff_beat_t u;
    u.phase             = phase_t'(d[2:0]);
    u.step              = atr_step_t'(d[6:3]);
    u.trace_valid       = d[7];
    u.trace_byte        = d[15:8];
    u.atr_started       = d[16];
    u.apdu_end          = d[17];
    u.ratio_load        = d[18];
    u.ratio_value       = d[28:19];
    u.ratio_unsupported = d[29];
    u.wait_load         = d[30];
    u.wait_time         = d[54:31];
    return u;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Watch config, input and result beats at each rising edge
  always @(posedge clk) begin : monitor
    sniff_beat_t want;
    sniff_beat_t got;
    if (rst) begin
      cfg_init_wait  = INIT_WAIT_RST;
      cfg_def_wi     = DEF_WI_RST;
      sess_phase     = PH_RESET;
      parse_step     = AS_TS;
      format_byte    = '0;
      group_cnt      = '0;
      hist_cnt       = '0;
      fi_code        = RATE_IDX_RST;
      di_code        = RATE_IDX_RST;
      wi             = DEF_WI_RST;
      clk_per_etu    = RATIO_RST;
      wait_etu       = INIT_WAIT_RST;
      mismatch_count = 0;
      predicted_beats.delete();
      outstanding    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_INIT_WAIT) cfg_init_wait = cfg_data[WAIT_W-1:0];
        else if (cfg_index == CFG_IDX_DEF_WI) cfg_def_wi = cfg_data[WI_W-1:0];
      end
      // result beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = unpack_beat(m_tdata);
        if (predicted_beats.size() == 0) begin
          $display("%0t: result beat expected none, got %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = predicted_beats.pop_front();
          check_field("phase", want.phase, got.phase);
          check_field("atr_step", want.step, got.step);
          check_field("trace_valid", want.trace_valid, got.trace_valid);
          check_field("trace_byte", want.trace_byte, got.trace_byte);
          check_field("atr_started", want.atr_started, got.atr_started);
          check_field("apdu_end", want.apdu_end, got.apdu_end);
          check_field("ratio_load", want.ratio_load, got.ratio_load);
          check_field("ratio_value", want.ratio_value, got.ratio_value);
          check_field("ratio_unsupported", want.ratio_unsupported, got.ratio_unsupported);
          check_field("wait_load", want.wait_load, got.wait_load);
          check_field("wait_time", want.wait_time, got.wait_time);
        end
      end
      if (s_tvalid && s_tready) begin
        advance_session(op_t'(s_tuser), s_tdata, want);
        predicted_beats.push_back(want);
      end
      outstanding = predicted_beats.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the smartcard ATR sniffer testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scatr_pkg::*;

  localparam int RANDOM_ITEMS   = 1600;
  localparam int DIRECTED_ITEMS = 24;
  localparam int CFG_INTERVAL   = 400;
  localparam int RX_HOLD_CYCLES = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte
  logic [IN_USER_W-1:0]  s_tuser = '0;   // [1:0] op
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // phase .. wait_time, see checker
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatch_count;
  int outstanding;
  int items_sent = 0;
  int tx_eager_left = 0;
  int rx_eager_left = 0;

  smartcard_atr_sniffer_top dut (.*);

  atr_session_checker session_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one beat after a random gap; returns at the falling edge after it is taken
  task automatic offer_char(input op_t op, input logic [7:0] b);
    int gap;
    if (tx_eager_left > 0) begin
      tx_eager_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 40) == 0) tx_eager_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // cfg_valid stays high; the caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain the block, then load both registers
  task automatic reconfigure(input logic [WAIT_W-1:0] init_wait, input logic [WI_W-1:0] def_wi);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    write_reg(CFG_IDX_INIT_WAIT, init_wait);
    write_reg(CFG_IDX_DEF_WI, {{(CFG_DATA_W-WI_W){1'b0}}, def_wi});
    cfg_valid <= 1'b0;
  endtask

  // One card session: reset release, an ATR built from its own presence bits, APDU traffic
  task automatic run_session();
    logic [7:0] t0;
    logic [7:0] td;
    logic [3:0] y;
    logic [3:0] hist;
    int         td_max;
    int         td_cnt;
    bit         cut;
    if ($urandom_range(0, 3) == 0) begin
      offer_char(OP_RESET_ON, any_byte());
      if ($urandom_range(0, 1) == 1) offer_char(OP_BYTE, any_byte());
    end
    offer_char(OP_RESET_OFF, any_byte());
    if ($urandom_range(0, 7) == 0) offer_char(OP_BYTE, 8'h00);
    offer_char(OP_BYTE, 8'($urandom_range(1, 255)));
    // long TD chains now and then, to saturate the group count
    td_max = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
    cut    = ($urandom_range(0, 7) == 0);
    td_cnt = 0;
    t0 = any_byte();
    if (td_max > 3) t0[7] = 1'b1;
    y    = t0[7:4];
    hist = t0[3:0];
    offer_char(OP_BYTE, t0);
    forever begin
      if (y[0]) offer_char(OP_BYTE, any_byte());
      if (y[1]) offer_char(OP_BYTE, any_byte());
      if (y[2]) offer_char(OP_BYTE, any_byte());
      if (!y[3]) break;
      td    = any_byte();
      td[7] = (td_cnt < td_max);
      td_cnt++;
      offer_char(OP_BYTE, td);
      y = td[7:4];
    end
    // broken ATR: stop before the historical bytes
    if (cut) return;
    repeat (hist) offer_char(OP_BYTE, any_byte());
    offer_char(OP_BYTE, any_byte());
    repeat ($urandom_range(0, 12)) begin
      if ($urandom_range(0, 5) == 0) offer_char(OP_EXPIRE, any_byte());
      else offer_char(OP_BYTE, any_byte());
    end
    // noise
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) offer_char(op_t'($urandom_range(0, 3)), any_byte());
    end
  endtask

  // Result side: random stalls, stretches without, and long hold-offs
  initial begin : receiver
    int hold;
    int taken;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == 300 || taken == 1000) begin
        hold = RX_HOLD_CYCLES;
      end else if (rx_eager_left > 0) begin
        rx_eager_left--;
        hold = 0;
      end else begin
        hold = $urandom_range(0, 9);
        if ($urandom_range(0, 40) == 0) rx_eager_left = $urandom_range(20, 60);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int next_cfg;
    int cfg_round;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    reconfigure(24'hFFFFFF, 8'd0);

    // directed: byte in reset, null TS, full two-group ATR with TA1 and TC2
    offer_char(OP_BYTE, 8'hFF);
    offer_char(OP_RESET_OFF, 8'h00);
    offer_char(OP_BYTE, 8'h00);
    offer_char(OP_BYTE, 8'h3B);
    offer_char(OP_BYTE, 8'hF1);
    offer_char(OP_BYTE, 8'h94);
    offer_char(OP_BYTE, 8'h00);
    offer_char(OP_BYTE, 8'hFF);
    offer_char(OP_BYTE, 8'hF0);
    offer_char(OP_BYTE, 8'h11);
    offer_char(OP_BYTE, 8'h55);
    offer_char(OP_BYTE, 8'hFF);
    offer_char(OP_BYTE, 8'h00);
    offer_char(OP_BYTE, 8'hAA);
    offer_char(OP_BYTE, 8'h5A);
    offer_char(OP_BYTE, 8'h12);
    offer_char(OP_EXPIRE, 8'hFF);
    offer_char(OP_RESET_ON, 8'h55);
    // no historical bytes, reserved Di: ratio refused and zero waiting time
    offer_char(OP_RESET_OFF, 8'hAA);
    offer_char(OP_BYTE, 8'h3F);
    offer_char(OP_BYTE, 8'h10);
    offer_char(OP_BYTE, 8'hD0);
    offer_char(OP_BYTE, 8'h00);
    offer_char(OP_BYTE, 8'h80);

    // random sessions, registers changed between phases
    next_cfg  = items_sent;
    cfg_round = 0;
    while (items_sent < RANDOM_ITEMS + DIRECTED_ITEMS) begin
      if (items_sent >= next_cfg) begin
        case (cfg_round % 4)
          0: reconfigure(24'd0, 8'd255);
          1: reconfigure(WAIT_W'($urandom_range(0, 24'hFFFFFF)), WI_W'($urandom_range(0, 255)));
          2: reconfigure(INIT_WAIT_RST, DEF_WI_RST);
          default: reconfigure(24'hFFFFFF, WI_W'($urandom_range(0, 255)));
        endcase
        cfg_round++;
        next_cfg = items_sent + CFG_INTERVAL;
      end
      run_session();
    end
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1_600_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
